[sv/bmmd_pkg.sv]
// Shared types, codes and constants of the bus memory map decoder.
`default_nettype none

package bmmd_pkg;

   localparam int DEFAULT_WORK_RAM_BANKS    = 8;
   localparam int DEFAULT_IO_REGISTER_COUNT = 76;

   localparam int BANK_OFFSET_W = 12;     // 4 KiB per work RAM bank
   localparam int VIDEO_DEPTH   = 8192;
   localparam int SPRITE_DEPTH  = 160;
   localparam int HIGH_DEPTH    = 128;
   localparam int OFFSET_W      = 13;
   localparam int CSR_INDEX_W   = 1;
   localparam int CSR_DATA_W    = 8;

   localparam logic [6:0] IO_WRITE_ONLY = 7'h46;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BOOT_ROM = 1'b0,
      CSR_RAM_BANK = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      STATUS_DONE    = 3'd0,
      STATUS_CART    = 3'd1,
      STATUS_IO      = 3'd2,
      STATUS_GAP     = 3'd3,
      STATUS_IO_NONE = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      SEL_NONE,
      SEL_BOOT,
      SEL_VIDEO,
      SEL_WORK,
      SEL_SPRITE,
      SEL_HIGH
   } sel_type;

   typedef struct packed {
      sel_type               target;
      logic                  wr;
      logic [OFFSET_W-1:0]   offset;
      status_type            status;
      logic [15:0]           ext_address;
      logic                  ext_write;
      logic [7:0]            ext_data;
      logic [7:0]            boot_data;
   } decode_type;

   localparam logic [7:0] BOOT_IMAGE [256] = '{
      8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
      8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
      8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
      8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
      8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
      8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
      8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
      8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
      8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hE2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
      8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
      8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
      8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
      8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
      8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h3C,
      8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
      8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
   };

   function automatic logic [7:0] boot_byte(input logic [7:0] idx);
      return BOOT_IMAGE[idx];
   endfunction

endpackage

`default_nettype wire

[sv/bmmd_ram.sv]
// Generic single-port RAM with registered read data.
`default_nettype none

module bmmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wdata,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[sv/bmmd_decode.sv]
// Address map decode of one bus beat: target store, offsets and forward fields.
`default_nettype none

module bmmd_decode
   import bmmd_pkg::*;
#(
   parameter int WORK_RAM_BANKS    = DEFAULT_WORK_RAM_BANKS,
   parameter int IO_REGISTER_COUNT = DEFAULT_IO_REGISTER_COUNT,
   localparam int BANK_W = (WORK_RAM_BANKS > 1) ? $clog2(WORK_RAM_BANKS) : 1,
   localparam int WORK_ADDR_W = BANK_W + BANK_OFFSET_W
) (
   input  wire logic                   command,
   input  wire logic [15:0]            address,
   input  wire logic [7:0]             write_data,
   input  wire logic                   boot_rom_enabled,
   input  wire logic [2:0]             ram_bank,
   output decode_type                  dec,
   output logic      [WORK_ADDR_W-1:0] work_addr
);

   localparam logic [3:0] BANK_LIMIT = 4'(WORK_RAM_BANKS);
   localparam logic [2:0] BANK_LAST  = 3'(WORK_RAM_BANKS - 1);
   localparam logic [7:0] IO_LIMIT   = 8'(IO_REGISTER_COUNT);

   logic [2:0] bank;
   logic [6:0] io_idx;
   logic       io_ok;

   // Bank zero reads as bank one; banks past the top saturate.
   always_comb begin
      bank = ram_bank;
      if (ram_bank == 3'd0) begin
         bank = 3'd1;
      end else if ({1'b0, ram_bank} >= BANK_LIMIT) begin
         bank = BANK_LAST;
      end
   end

   assign io_idx = address[6:0];

   always_comb begin
      io_ok = 1'b0;
      if ({1'b0, io_idx} < IO_LIMIT) begin
         if (io_idx == IO_WRITE_ONLY) begin
            io_ok = command;
         end else begin
            io_ok = io_idx inside {7'h00, [7'h04:7'h07], 7'h0F, [7'h40:7'h4B]};
         end
      end
   end

   always_comb begin
      dec             = '0;
      dec.target      = SEL_NONE;
      dec.status      = STATUS_DONE;
      dec.wr          = command;
      dec.offset      = address[OFFSET_W-1:0];
      work_addr       = '0;
      case (address) inside
         [16'h0000:16'h7FFF], [16'hA000:16'hBFFF]: begin
            if (!command && address[15:8] == 8'h00 && boot_rom_enabled) begin
               dec.target    = SEL_BOOT;
               dec.boot_data = boot_byte(address[7:0]);
            end else begin
               dec.status      = STATUS_CART;
               dec.ext_address = address;
            end
         end
         [16'h8000:16'h9FFF]: begin
            dec.target = SEL_VIDEO;
         end
         [16'hC000:16'hFDFF]: begin
            // Bit 12 splits fixed and banked halves, also in the mirror.
            dec.target = SEL_WORK;
            if (address[12]) begin
               work_addr = {bank[BANK_W-1:0], address[BANK_OFFSET_W-1:0]};
            end else begin
               work_addr = {{BANK_W{1'b0}}, address[BANK_OFFSET_W-1:0]};
            end
         end
         [16'hFE00:16'hFE9F]: begin
            dec.target = SEL_SPRITE;
         end
         [16'hFEA0:16'hFEFF]: begin
            dec.status = STATUS_GAP;
         end
         [16'hFF00:16'hFF7F]: begin
            if (io_ok) begin
               dec.status      = STATUS_IO;
               dec.ext_address = {9'd0, io_idx};
            end else begin
               dec.status = STATUS_IO_NONE;
            end
         end
         default: begin
            dec.target = SEL_HIGH;
         end
      endcase
      if (dec.status == STATUS_CART || dec.status == STATUS_IO) begin
         dec.ext_write = command;
         dec.ext_data  = command ? write_data : 8'd0;
      end
   end

endmodule

`default_nettype wire

[sv/bus_memory_map_decoder.sv]
// Top level of the bus memory map decoder: handshake, stores and result register.
`default_nettype none

// Decodes one byte read or write per beat against a 16-bit map and answers with
// one result beat. A beat is accepted every cycle while results flow; a result
// passes the registered read port of the internal RAMs (video, work, sprite
// and high RAM), then the result register. Internal RAM contents are undefined
// after reset until written; no clearing pass runs, so requests are taken from
// the first cycle after reset. Configuration (boot ROM overlay, work RAM bank)
// is written through the csr_ port; the user must write it only while no
// request is in flight, not enforced by the block; csr_ready is always high.
module bus_memory_map_decoder
   import bmmd_pkg::*;
#(
   parameter int WORK_RAM_BANKS    = DEFAULT_WORK_RAM_BANKS,
   parameter int IO_REGISTER_COUNT = DEFAULT_IO_REGISTER_COUNT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,

   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic                   req_command,
   input  wire logic [15:0]            req_address,
   input  wire logic [7:0]             req_write_data,

   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic      [7:0]             rsp_read_data,
   output logic      [2:0]             rsp_status,
   output logic      [15:0]            rsp_ext_address,
   output logic                        rsp_ext_write,
   output logic      [7:0]             rsp_ext_data,

   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int BANK_W      = (WORK_RAM_BANKS > 1) ? $clog2(WORK_RAM_BANKS) : 1;
   localparam int WORK_ADDR_W = BANK_W + BANK_OFFSET_W;
   localparam int WORK_DEPTH  = WORK_RAM_BANKS << BANK_OFFSET_W;

   // Configuration registers
   logic       boot_rom_enabled_ff;
   logic [2:0] ram_bank_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_rom_enabled_ff <= 1'b1;
         ram_bank_ff         <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_BOOT_ROM: boot_rom_enabled_ff <= csr_write_data[0];
            CSR_RAM_BANK: ram_bank_ff         <= csr_write_data[2:0];
            default: ;
         endcase
      end
   end

   // Decode
   decode_type             dec;
   logic [WORK_ADDR_W-1:0] work_addr;

   bmmd_decode #(
      .WORK_RAM_BANKS    (WORK_RAM_BANKS),
      .IO_REGISTER_COUNT (IO_REGISTER_COUNT)
   ) u_decode (
      .command          (req_command),
      .address          (req_address),
      .write_data       (req_write_data),
      .boot_rom_enabled (boot_rom_enabled_ff),
      .ram_bank         (ram_bank_ff),
      .dec              (dec),
      .work_addr        (work_addr)
   );

   // Handshake
   logic req_fire;
   logic out_free;
   logic s1_valid_ff;
   logic s1_valid_in;
   decode_type s1_dec_ff;
   logic rsp_valid_ff;
   logic rsp_valid_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_fire  = req_valid && !req_stall;

   // Stores
   logic       video_sel;
   logic       work_sel;
   logic       sprite_sel;
   logic       high_sel;
   logic [7:0] video_rdata;
   logic [7:0] work_rdata;
   logic [7:0] sprite_rdata;
   logic [7:0] high_rdata;

   assign video_sel  = req_fire && dec.target == SEL_VIDEO;
   assign work_sel   = req_fire && dec.target == SEL_WORK;
   assign sprite_sel = req_fire && dec.target == SEL_SPRITE;
   assign high_sel   = req_fire && dec.target == SEL_HIGH;

   bmmd_ram #(.WIDTH(8), .DEPTH(VIDEO_DEPTH)) u_video_ram (
      .clock (clock),
      .we    (video_sel && dec.wr),
      .re    (video_sel && !dec.wr),
      .addr  (dec.offset[12:0]),
      .wdata (req_write_data),
      .rdata (video_rdata)
   );

   bmmd_ram #(.WIDTH(8), .DEPTH(WORK_DEPTH)) u_work_ram (
      .clock (clock),
      .we    (work_sel && dec.wr),
      .re    (work_sel && !dec.wr),
      .addr  (work_addr),
      .wdata (req_write_data),
      .rdata (work_rdata)
   );

   bmmd_ram #(.WIDTH(8), .DEPTH(SPRITE_DEPTH)) u_sprite_ram (
      .clock (clock),
      .we    (sprite_sel && dec.wr),
      .re    (sprite_sel && !dec.wr),
      .addr  (dec.offset[7:0]),
      .wdata (req_write_data),
      .rdata (sprite_rdata)
   );

   bmmd_ram #(.WIDTH(8), .DEPTH(HIGH_DEPTH)) u_high_ram (
      .clock (clock),
      .we    (high_sel && dec.wr),
      .re    (high_sel && !dec.wr),
      .addr  (dec.offset[6:0]),
      .wdata (req_write_data),
      .rdata (high_rdata)
   );

   // Stage 1: read in flight. RAM read data holds while this stage waits,
   // since no new beat is accepted then.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (out_free) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_dec_ff <= dec;
      end
   end

   // Result register
   logic [7:0]  read_data_in;
   logic [7:0]  read_data_ff;
   status_type  status_ff;
   logic [15:0] ext_address_ff;
   logic        ext_write_ff;
   logic [7:0]  ext_data_ff;

   always_comb begin
      read_data_in = 8'd0;
      if (!s1_dec_ff.wr) begin
         case (s1_dec_ff.target)
            SEL_BOOT:   read_data_in = s1_dec_ff.boot_data;
            SEL_VIDEO:  read_data_in = video_rdata;
            SEL_WORK:   read_data_in = work_rdata;
            SEL_SPRITE: read_data_in = sprite_rdata;
            SEL_HIGH:   read_data_in = high_rdata;
            default:    read_data_in = 8'd0;
         endcase
      end
   end

   assign rsp_valid_in = out_free ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && s1_valid_ff) begin
         read_data_ff   <= read_data_in;
         status_ff      <= s1_dec_ff.status;
         ext_address_ff <= s1_dec_ff.ext_address;
         ext_write_ff   <= s1_dec_ff.ext_write;
         ext_data_ff    <= s1_dec_ff.ext_data;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_data   = read_data_ff;
   assign rsp_status      = status_ff;
   assign rsp_ext_address = ext_address_ff;
   assign rsp_ext_write   = ext_write_ff;
   assign rsp_ext_data    = ext_data_ff;

   // A stalled result must keep the stage behind it occupied.
   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff)
      else $error("stage 1 lost while result stalled");

   // Only forwarded beats carry forward fields.
   a_fwd_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_CART && status_ff != STATUS_IO
      |-> ext_write_ff == 1'b0 && ext_data_ff == 8'd0 && ext_address_ff == 16'd0)
      else $error("forward fields set on a non-forwarded result");

   // Beats that are not done internally return no read data.
   a_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != STATUS_DONE |-> read_data_ff == 8'd0)
      else $error("read data on a forwarded or rejected result");

   // An accepted beat shows up at the result register when it is free.
   a_advance: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_free |=> rsp_valid_ff)
      else $error("stage 1 beat did not reach the result register");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for the bus memory map decoder.
`timescale 1ns / 1ps

module tb_top;
   import bmmd_pkg::*;

   localparam bit CMD_READ  = 1'b0;
   localparam bit CMD_WRITE = 1'b1;

   localparam int IO_REGISTERS = DEFAULT_IO_REGISTER_COUNT;
   localparam int WORK_BANKS   = DEFAULT_WORK_RAM_BANKS;
   localparam int BANK_BYTES   = 4096;
   localparam int VIDEO_BASE   = 0;
   localparam int WORK_BASE    = VIDEO_BASE + VIDEO_DEPTH;
   localparam int SPRITE_BASE  = WORK_BASE + WORK_BANKS * BANK_BYTES;
   localparam int HIGH_BASE    = SPRITE_BASE + SPRITE_DEPTH;
   localparam int RAM_SLOTS    = HIGH_BASE + HIGH_DEPTH;

   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_OFF     = 300;
   localparam int IDLE_PERCENT = 7;

   localparam logic [7:0] BOOT_BYTES [256] = '{
      8'h31,8'hFE,8'hFF,8'hAF,8'h21,8'hFF,8'h9F,8'h32,8'hCB,8'h7C,8'h20,8'hFB,8'h21,8'h26,8'hFF,8'h0E,
      8'h11,8'h3E,8'h80,8'h32,8'hE2,8'h0C,8'h3E,8'hF3,8'hE2,8'h32,8'h3E,8'h77,8'h77,8'h3E,8'hFC,8'hE0,
      8'h47,8'h11,8'h04,8'h01,8'h21,8'h10,8'h80,8'h1A,8'hCD,8'h95,8'h00,8'hCD,8'h96,8'h00,8'h13,8'h7B,
      8'hFE,8'h34,8'h20,8'hF3,8'h11,8'hD8,8'h00,8'h06,8'h08,8'h1A,8'h13,8'h22,8'h23,8'h05,8'h20,8'hF9,
      8'h3E,8'h19,8'hEA,8'h10,8'h99,8'h21,8'h2F,8'h99,8'h0E,8'h0C,8'h3D,8'h28,8'h08,8'h32,8'h0D,8'h20,
      8'hF9,8'h2E,8'h0F,8'h18,8'hF3,8'h67,8'h3E,8'h64,8'h57,8'hE0,8'h42,8'h3E,8'h91,8'hE0,8'h40,8'h04,
      8'h1E,8'h02,8'h0E,8'h0C,8'hF0,8'h44,8'hFE,8'h90,8'h20,8'hFA,8'h0D,8'h20,8'hF7,8'h1D,8'h20,8'hF2,
      8'h0E,8'h13,8'h24,8'h7C,8'h1E,8'h83,8'hFE,8'h62,8'h28,8'h06,8'h1E,8'hC1,8'hFE,8'h64,8'h20,8'h06,
      8'h7B,8'hE2,8'h0C,8'h3E,8'h87,8'hE2,8'hF0,8'h42,8'h90,8'hE0,8'h42,8'h15,8'h20,8'hD2,8'h05,8'h20,
      8'h4F,8'h16,8'h20,8'h18,8'hCB,8'h4F,8'h06,8'h04,8'hC5,8'hCB,8'h11,8'h17,8'hC1,8'hCB,8'h11,8'h17,
      8'h05,8'h20,8'hF5,8'h22,8'h23,8'h22,8'h23,8'hC9,8'hCE,8'hED,8'h66,8'h66,8'hCC,8'h0D,8'h00,8'h0B,
      8'h03,8'h73,8'h00,8'h83,8'h00,8'h0C,8'h00,8'h0D,8'h00,8'h08,8'h11,8'h1F,8'h88,8'h89,8'h00,8'h0E,
      8'hDC,8'hCC,8'h6E,8'hE6,8'hDD,8'hDD,8'hD9,8'h99,8'hBB,8'hBB,8'h67,8'h63,8'h6E,8'h0E,8'hEC,8'hCC,
      8'hDD,8'hDC,8'h99,8'h9F,8'hBB,8'hB9,8'h33,8'h3E,8'h3C,8'h42,8'hB9,8'hA5,8'hB9,8'hA5,8'h42,8'h3C,
      8'h21,8'h04,8'h01,8'h11,8'hA8,8'h00,8'h1A,8'h13,8'hBE,8'h20,8'hFE,8'h23,8'h7D,8'hFE,8'h34,8'h20,
      8'hF5,8'h06,8'h19,8'h78,8'h86,8'h23,8'h05,8'h20,8'hFB,8'h86,8'h20,8'hFE,8'h3E,8'h01,8'hE0,8'h50
   };

   typedef struct packed {
      logic [7:0]  read_data;
      status_type  status;
      logic [15:0] ext_address;
      logic        ext_write;
      logic [7:0]  ext_data;
   } bus_answer_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic          req_command = 1'b0;
   logic [15:0]   req_address = '0;
   logic [7:0]    req_write_data = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [7:0]    rsp_read_data;
   logic [2:0]    rsp_status;
   logic [15:0]   rsp_ext_address;
   logic          rsp_ext_write;
   logic [7:0]    rsp_ext_data;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_BOOT_ROM;
   logic [7:0]    csr_write_data = '0;

   // shadow of the decoder's stores and settings
   logic [7:0]    ram_copy [RAM_SLOTS];
   bit            ram_written [RAM_SLOTS];
   logic [15:0]   written_addrs [$];
   bit            boot_rom_on = 1'b1;
   logic [2:0]    ram_bank_sel = 3'd1;

   bus_answer_type answer_q [$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   bit            hold_off_request = 1'b0;
   bit            hold_off_taken = 1'b0;
   int            hold_off_left = 0;
   bit            sender_idles = 1'b1;
   bit            receiver_idles = 1'b1;

   bus_memory_map_decoder DUT (.*);

   always #2 clock = ~clock;

   function automatic int active_bank();
      int b;
      b = int'(ram_bank_sel);
      if (b == 0) b = 1;
      if (b >= WORK_BANKS) b = WORK_BANKS - 1;
      return b;
   endfunction

   // flat shadow index of an internal RAM byte, -1 outside internal RAM
   function automatic int map_slot(input logic [15:0] a);
      logic [15:0] off;
      if (a >= 16'h8000 && a < 16'hA000) return VIDEO_BASE + int'(a - 16'h8000);
      if (a >= 16'hC000 && a < 16'hFE00) begin
         off = (a >= 16'hE000) ? a - 16'h2000 : a;
         if (off < 16'hD000) return WORK_BASE + int'(off - 16'hC000);
         return WORK_BASE + active_bank() * BANK_BYTES + int'(off - 16'hD000);
      end
      if (a >= 16'hFE00 && a < 16'hFEA0) return SPRITE_BASE + int'(a - 16'hFE00);
      if (a >= 16'hFF80) return HIGH_BASE + int'(a - 16'hFF80);
      return -1;
   endfunction

   function automatic bit unwritten_slot(input logic [15:0] a);
      int slot;
      slot = map_slot(a);
      return slot >= 0 && !ram_written[slot];
   endfunction

   function automatic bit io_handled(input logic [6:0] idx, input bit wr);
      if (int'(idx) >= IO_REGISTERS) return 1'b0;
      if (idx == 7'h00 || (idx >= 7'h04 && idx <= 7'h07) || idx == 7'h0F) return 1'b1;
      if (idx == IO_WRITE_ONLY) return wr;
      return idx >= 7'h40 && idx <= 7'h4B;
   endfunction

   function automatic bus_answer_type decode_access(input bit cmd, input logic [15:0] a,
                                                    input logic [7:0] d);
      bus_answer_type ans;
      int          slot;
      logic [15:0] io_idx;
      ans = '0;
      slot = map_slot(a);
      if (slot >= 0) begin
         if (cmd == CMD_WRITE) begin
            ram_copy[slot] = d;
            ram_written[slot] = 1'b1;
            written_addrs.push_back(a);
         end else begin
            ans.read_data = ram_copy[slot];
         end
      end else if (a < 16'h8000 || (a >= 16'hA000 && a < 16'hC000)) begin
         if (cmd == CMD_READ && a < 16'h0100 && boot_rom_on) begin
            ans.read_data = BOOT_BYTES[a[7:0]];
         end else begin
            ans.status = STATUS_CART;
            ans.ext_address = a;
         end
      end else if (a < 16'hFF00) begin
         ans.status = STATUS_GAP;
      end else begin
         io_idx = a - 16'hFF00;
         if (io_handled(io_idx[6:0], cmd)) begin
            ans.status = STATUS_IO;
            ans.ext_address = io_idx;
         end else begin
            ans.status = STATUS_IO_NONE;
         end
      end
      if (ans.status == STATUS_CART || ans.status == STATUS_IO) begin
         ans.ext_write = cmd;
         ans.ext_data = (cmd == CMD_WRITE) ? d : 8'h00;
      end
      return ans;
   endfunction

   task automatic send_beat(input bit cmd, input logic [15:0] addr, input logic [7:0] data);
      while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_address <= addr;
      req_write_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      answer_q.push_back(decode_access(cmd, addr, data));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type which, input logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_write_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (which)
         CSR_BOOT_ROM: boot_rom_on = value[0];
         CSR_RAM_BANK: ram_bank_sel = value[2:0];
         default: ;
      endcase
   endtask

   // upper data bits are random and must be dropped by the block
   task automatic apply_settings(input bit boot_on, input logic [2:0] bank);
      logic [7:0] junk;
      wait_drained();
      junk = 8'($urandom);
      write_register(CSR_BOOT_ROM, {junk[7:1], boot_on});
      junk = 8'($urandom);
      write_register(CSR_RAM_BANK, {junk[7:3], bank});
      csr_valid <= 1'b0;
   endtask

   task automatic pick_access(output bit cmd, output logic [15:0] addr, output logic [7:0] data);
      int unsigned roll;
      logic [15:0] r;
      roll = $urandom_range(99);
      r = 16'($urandom);
      data = 8'($urandom);
      cmd = 1'($urandom_range(1));
      if (roll < 12) begin
         addr = {1'b0, r[14:0]};
      end else if (roll < 20) begin
         addr = {8'h00, r[7:0]};
      end else if (roll < 25) begin
         addr = 16'hA000 + {3'b000, r[12:0]};
      end else if (roll < 45 && written_addrs.size() != 0) begin
         // read back something stored earlier, often through the mirror
         addr = written_addrs[$urandom_range(written_addrs.size() - 1)];
         cmd = CMD_READ;
         if (r[15] && addr >= 16'hC000 && addr < 16'hDE00) addr = addr + 16'h2000;
         else if (r[15] && addr >= 16'hE000 && addr < 16'hFE00) addr = addr - 16'h2000;
      end else if (roll < 70) begin
         case ($urandom_range(4))
            0: addr = 16'h8000 + {3'b000, r[12:0]};
            1: addr = (r[15] ? 16'hE000 : 16'hC000) + {4'h0, r[11:0]};
            2: addr = r[15] ? 16'hD000 + {4'h0, r[11:0]}
                            : 16'hF000 + ({4'h0, r[11:0]} % 16'hE00);
            3: addr = 16'hFE00 + 16'(int'(r[7:0]) % SPRITE_DEPTH);
            default: addr = 16'hFF80 + {9'd0, r[6:0]};
         endcase
      end else if (roll < 76) begin
         addr = 16'hFEA0 + 16'(int'(r[6:0]) % 96);
      end else if (roll < 92) begin
         addr = 16'hFF00 + {9'd0, r[6:0]};
      end else begin
         addr = r;
      end
      // never read an entry that holds nothing yet: store to it instead
      if (cmd == CMD_READ && unwritten_slot(addr)) cmd = CMD_WRITE;
   endtask

   task automatic random_traffic(input int count);
      bit          cmd;
      logic [15:0] addr;
      logic [7:0]  data;
      repeat (count) begin
         pick_access(cmd, addr, data);
         send_beat(cmd, addr, data);
      end
   endtask

   task automatic test_directed_map();
      send_beat(CMD_READ,  16'h0000, 8'h00);
      send_beat(CMD_READ,  16'h00FF, 8'hFF);
      send_beat(CMD_WRITE, 16'h0000, 8'hA5);   // boot overlay never catches writes
      send_beat(CMD_READ,  16'h0100, 8'h00);
      send_beat(CMD_READ,  16'h7FFF, 8'h00);
      send_beat(CMD_WRITE, 16'hBFFF, 8'h5A);
      send_beat(CMD_WRITE, 16'h8000, 8'hFF);
      send_beat(CMD_WRITE, 16'h9FFF, 8'h00);
      send_beat(CMD_READ,  16'h9FFF, 8'h00);
      send_beat(CMD_WRITE, 16'hC000, 8'h12);
      send_beat(CMD_READ,  16'hE000, 8'h00);
      send_beat(CMD_WRITE, 16'hD000, 8'h34);
      send_beat(CMD_READ,  16'hF000, 8'h00);
      send_beat(CMD_WRITE, 16'hFDFF, 8'h56);
      send_beat(CMD_READ,  16'hDDFF, 8'h00);
      send_beat(CMD_WRITE, 16'hFE9F, 8'h9A);
      send_beat(CMD_READ,  16'hFE9F, 8'h00);
      send_beat(CMD_READ,  16'hFEA0, 8'h00);
      send_beat(CMD_WRITE, 16'hFEFF, 8'h77);
      send_beat(CMD_READ,  16'hFF00, 8'h00);
      send_beat(CMD_READ,  16'hFF46, 8'h00);   // write-only register
      send_beat(CMD_WRITE, 16'hFF46, 8'hC3);
      send_beat(CMD_WRITE, 16'hFF4B, 8'h3C);
      send_beat(CMD_READ,  16'hFF4C, 8'h00);   // past the register count
      send_beat(CMD_READ,  16'hFF01, 8'h00);   // no handler
      send_beat(CMD_WRITE, 16'hFFFF, 8'h7E);
      send_beat(CMD_READ,  16'hFFFF, 8'h00);
   endtask

   task automatic test_settings();
      bit         boot_steps [10];
      logic [2:0] bank_steps [10];
      logic [7:0] data;
      boot_steps = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
      bank_steps = '{3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd1, 3'd7, 3'd0};
      for (int i = 0; i < 10; i++) begin
         apply_settings(boot_steps[i], bank_steps[i]);
         data = 8'($urandom);
         send_beat(CMD_READ, 16'(i * 16'h1B), 8'h00);
         // bank zero falls back to bank one, so this may hit the earlier write
         if (!unwritten_slot(16'hD000)) send_beat(CMD_READ, 16'hD000, 8'h00);
         send_beat(CMD_WRITE, 16'hD000 + 16'(i * 16'h111), data);
         send_beat(CMD_READ, 16'hF000 + 16'(i * 16'h111), 8'h00);
         random_traffic(50);
      end
   endtask

   task automatic test_random_traffic();
      apply_settings(1'b0, 3'd3);
      random_traffic(300);
      sender_idles = 1'b0;
      receiver_idles = 1'b0;
      random_traffic(150);
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      apply_settings(1'b1, 3'd6);
      random_traffic(100);
   endtask

   task automatic test_backpressure();
      sender_idles = 1'b0;
      hold_off_request = 1'b1;
      random_traffic(60);
      sender_idles = 1'b1;
   endtask

   task automatic compare_field(input string what, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
      end
   endtask

   // check each result beat, then drive the next stall
   always @(posedge clock) begin
      bus_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_q.size() == 0) begin
            error_count++;
            $display("%0t: result beat with none expected, status %0d", $time, rsp_status);
         end else begin
            want = answer_q.pop_front();
            compare_field("read_data", 16'(want.read_data), 16'(rsp_read_data));
            compare_field("status", 16'(want.status), 16'(rsp_status));
            compare_field("ext_address", want.ext_address, rsp_ext_address);
            compare_field("ext_write", 16'(want.ext_write), 16'(rsp_ext_write));
            compare_field("ext_data", 16'(want.ext_data), 16'(rsp_ext_data));
         end
      end
      // start the long hold-off once, when asked for
      if (hold_off_request && !hold_off_taken) begin
         hold_off_taken = 1'b1;
         hold_off_left = HOLD_OFF;
      end
      if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left = hold_off_left - 1;
      end else begin
         rsp_stall <= receiver_idles && ($urandom_range(99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL bus_memory_map_decoder");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_directed_map();
      test_settings();
      test_random_traffic();
      test_backpressure();
      wait_drained();
      repeat (8) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS bus_memory_map_decoder");
      end else begin
         $display("FAIL bus_memory_map_decoder");
      end
      $finish;
   end

endmodule
